[rtl/amr_storage_frame_scanner_top_defines.svh]
// Assertion macros for the AMR storage frame scanner.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef AMR_STORAGE_FRAME_SCANNER_TOP_DEFINES_SVH
`define AMR_STORAGE_FRAME_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define AMR_SFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define AMR_SFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/amr_sfs_pkg.sv]
// Shared constants, tables, functions and types of the AMR storage frame scanner.
// No dependencies; imported by every module of the block.
package amr_sfs_pkg;

    localparam int COUNT_WIDTH       = 32;
    localparam int FRAMES_PER_SEC    = 50;
    localparam int SUB_WIDTH         = $clog2(FRAMES_PER_SEC);
    localparam logic [4:0] HDR_SCAN_LIMIT = 5'd15;

    // Event codes of a result word
    localparam logic [2:0] EV_HDR      = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_GOOD     = 3'd2;
    localparam logic [2:0] EV_NEW_MODE = 3'd3;
    localparam logic [2:0] EV_SID      = 3'd4;
    localparam logic [2:0] EV_NOISE    = 3'd5;
    localparam logic [2:0] EV_BAD      = 3'd6;
    localparam logic [2:0] EV_FMT_ERR  = 3'd7;

    // Stream formats
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_NB      = 2'd1;
    localparam logic [1:0] FMT_WB      = 2'd2;

    // Frame header fields
    localparam logic [7:0] HDR_MASK    = 8'h87;
    localparam logic [7:0] HDR_MATCH   = 8'h04;
    localparam logic [3:0] FT_NB_MAX   = 4'd7;
    localparam logic [3:0] FT_WB_MAX   = 4'd8;
    localparam logic [3:0] FT_SID_LO   = 4'd8;
    localparam logic [3:0] FT_SID_HI   = 4'd11;
    localparam logic [3:0] FT_NOISE_WB = 4'd9;

    // Candidate magics: mono NB, mono WB, multichannel NB, multichannel WB
    localparam int NUM_MAGIC = 4;
    localparam logic [7:0] MAGIC_TEXT [NUM_MAGIC][16] = '{
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h0A, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h2D, 8'h57, 8'h42,
          8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h5F, 8'h4D, 8'h43,
          8'h31, 8'h2E, 8'h30, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h2D, 8'h57, 8'h42,
          8'h5F, 8'h4D, 8'h43, 8'h31, 8'h2E, 8'h30, 8'h0A, 8'h00}
    };
    localparam logic [4:0] MAGIC_LEN [NUM_MAGIC]   = '{5'd6, 5'd9, 5'd12, 5'd15};
    localparam logic       MAGIC_MULTI [NUM_MAGIC] = '{1'b0, 1'b0, 1'b1, 1'b1};
    localparam logic [1:0] MAGIC_FMT [NUM_MAGIC]   = '{FMT_NB, FMT_WB, FMT_NB, FMT_WB};
    localparam logic [4:0] MULTI_EXTRA = 5'd3;

    // Result of one magic byte
    typedef struct packed {
        logic [3:0] flags;
        logic [4:0] pos;
        logic       err;
        logic       done;
        logic [1:0] fmt;
        logic [3:0] chans;
    } amr_sfs_hdr_res_t;

    // Result of one hunted byte
    typedef struct packed {
        logic [2:0] ev;
        logic       relock;
        logic       count;
        logic       set_irr;
    } amr_sfs_hunt_res_t;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    // Frame size in bytes, header included
    function automatic logic [5:0] mode_size(input logic [1:0] fmt, input logic [3:0] ft);
        logic [5:0] r;
        r = '0;
        if (fmt == FMT_NB) begin
            case (ft)
                4'd0: r = 6'd13;
                4'd1: r = 6'd14;
                4'd2: r = 6'd16;
                4'd3: r = 6'd18;
                4'd4: r = 6'd20;
                4'd5: r = 6'd21;
                4'd6: r = 6'd27;
                4'd7: r = 6'd32;
                4'd8: r = 6'd6;
                default: r = '0;
            endcase
        end else if (fmt == FMT_WB) begin
            case (ft)
                4'd0: r = 6'd18;
                4'd1: r = 6'd24;
                4'd2: r = 6'd33;
                4'd3: r = 6'd37;
                4'd4: r = 6'd41;
                4'd5: r = 6'd47;
                4'd6: r = 6'd51;
                4'd7: r = 6'd59;
                4'd8: r = 6'd61;
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    // Bitrate in units of 10 bit/s
    function automatic logic [11:0] mode_rate(input logic [1:0] fmt, input logic [3:0] ft);
        logic [11:0] r;
        r = '0;
        if (fmt == FMT_NB) begin
            case (ft)
                4'd0: r = 12'd475;
                4'd1: r = 12'd515;
                4'd2: r = 12'd590;
                4'd3: r = 12'd670;
                4'd4: r = 12'd740;
                4'd5: r = 12'd795;
                4'd6: r = 12'd1020;
                4'd7: r = 12'd1220;
                4'd8: r = 12'd180;
                default: r = '0;
            endcase
        end else if (fmt == FMT_WB) begin
            case (ft)
                4'd0: r = 12'd660;
                4'd1: r = 12'd885;
                4'd2: r = 12'd1265;
                4'd3: r = 12'd1425;
                4'd4: r = 12'd1585;
                4'd5: r = 12'd1825;
                4'd6: r = 12'd1985;
                4'd7: r = 12'd2305;
                4'd8: r = 12'd2385;
                default: r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/amr_sfs_magic.sv]
// Magic checker: matches one file header byte against the four candidate magics.
// Depends on amr_sfs_pkg.
module amr_sfs_magic (
    input  logic [7:0]                    data_byte,
    input  logic [4:0]                    pos,
    input  logic [3:0]                    flags,
    output amr_sfs_pkg::amr_sfs_hdr_res_t res
);
    import amr_sfs_pkg::*;

    logic [7:0] upper;
    logic [3:0] flags_mid;
    logic       in_extra;

    assign upper = to_upper(data_byte);

    // Drop every live candidate whose text differs at this position
    always_comb begin
        flags_mid = flags;
        in_extra  = 1'b0;
        for (int k = 0; k < NUM_MAGIC; k++) begin
            if (flags[k]) begin
                if (pos < MAGIC_LEN[k]) begin
                    if (upper != MAGIC_TEXT[k][pos[3:0]]) begin
                        flags_mid[k] = 1'b0;
                    end
                end else begin
                    in_extra = 1'b1;
                end
            end
        end
        if (pos >= HDR_SCAN_LIMIT && !in_extra) begin
            flags_mid = '0;
        end
    end

    // Detect the end of a surviving magic and take format and channels
    always_comb begin
        res       = '0;
        res.flags = flags_mid;
        res.pos   = pos + 5'd1;
        res.err   = (flags_mid == '0);
        res.fmt   = FMT_UNKNOWN;
        res.chans = 4'd1;
        for (int k = 0; k < NUM_MAGIC; k++) begin
            if (flags_mid[k]) begin
                if (!MAGIC_MULTI[k] && pos == MAGIC_LEN[k] - 5'd1) begin
                    res.done  = 1'b1;
                    res.fmt   = MAGIC_FMT[k];
                    res.chans = 4'd1;
                end else if (MAGIC_MULTI[k] && pos == MAGIC_LEN[k] + MULTI_EXTRA) begin
                    res.done  = 1'b1;
                    res.fmt   = MAGIC_FMT[k];
                    res.chans = data_byte[3:0];
                end
            end
        end
    end

endmodule

[rtl/amr_sfs_hunt.sv]
// Frame header classifier: sorts one hunted byte into good, new mode, SID, noise or bad.
// Depends on amr_sfs_pkg.
module amr_sfs_hunt (
    input  logic [7:0]                     data_byte,
    input  logic [1:0]                     fmt,
    input  logic [7:0]                     locked,
    input  logic                           have_lock,
    output amr_sfs_pkg::amr_sfs_hunt_res_t res
);
    import amr_sfs_pkg::*;

    logic [3:0] ft;
    logic       hdr_ok;
    logic       is_nb;
    logic       speech;

    assign ft     = data_byte[6:3];
    assign hdr_ok = (data_byte & HDR_MASK) == HDR_MATCH;
    assign is_nb  = (fmt == FMT_NB);
    assign speech = hdr_ok && (is_nb ? (ft <= FT_NB_MAX) : (ft <= FT_WB_MAX));

    // Classify the byte; only speech headers count
    always_comb begin
        res = '0;
        if (have_lock && data_byte == locked) begin
            res.ev    = EV_GOOD;
            res.count = 1'b1;
        end else if (speech) begin
            res.ev      = EV_NEW_MODE;
            res.relock  = 1'b1;
            res.count   = 1'b1;
            res.set_irr = have_lock;
        end else begin
            res.set_irr = 1'b1;
            if (is_nb && hdr_ok && (ft inside {[FT_SID_LO:FT_SID_HI]})) begin
                res.ev = EV_SID;
            end else if (!is_nb && hdr_ok && ft == FT_NOISE_WB) begin
                res.ev = EV_NOISE;
            end else begin
                res.ev = EV_BAD;
            end
        end
    end

endmodule

[rtl/amr_sfs_count.sv]
// Saturating good-frame counter with an incremental seconds count (50 frames a second).
// Depends on amr_sfs_pkg.
module amr_sfs_count (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic                                clear,
    input  logic                                inc,
    output logic [amr_sfs_pkg::COUNT_WIDTH-1:0] frames_next,
    output logic [amr_sfs_pkg::COUNT_WIDTH-1:0] secs_next
);
    import amr_sfs_pkg::*;

    logic [COUNT_WIDTH-1:0] frames_reg;
    logic [COUNT_WIDTH-1:0] secs_reg;
    logic [SUB_WIDTH-1:0]   sub_reg;
    logic [SUB_WIDTH-1:0]   sub_next;
    logic                   bump;

    // Advance the count unless it has saturated; wrap the sub-second count
    always_comb begin
        bump        = inc && !(&frames_reg);
        frames_next = frames_reg;
        secs_next   = secs_reg;
        sub_next    = sub_reg;
        if (bump) begin
            frames_next = frames_reg + COUNT_WIDTH'(1);
            if (sub_reg == SUB_WIDTH'(FRAMES_PER_SEC - 1)) begin
                sub_next  = '0;
                secs_next = secs_reg + COUNT_WIDTH'(1);
            end else begin
                sub_next = sub_reg + SUB_WIDTH'(1);
            end
        end
    end

    // Hold the counts; clear them after the last word of a file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= '0;
            secs_reg   <= '0;
            sub_reg    <= '0;
        end else if (advance) begin
            if (clear) begin
                frames_reg <= '0;
                secs_reg   <= '0;
                sub_reg    <= '0;
            end else begin
                frames_reg <= frames_next;
                secs_reg   <= secs_next;
                sub_reg    <= sub_next;
            end
        end
    end

endmodule

[rtl/amr_storage_frame_scanner_top.sv]
// AMR storage frame scanner: one file byte per word in, one result word out per byte.
// Each word passes through the input register, then the result register. Throughput: one
// word per cycle while the result is taken (m_ready low holds the flow); the scan state
// updates once per word as it moves from the input register to the result register.
// Reset: synchronous active-low aresetn empties both registers and returns the scan
// to the file header phase; the last byte of a file does the same to the scan state.
module amr_storage_frame_scanner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [1:0]  m_format,
    output logic [3:0]  m_channels,
    output logic [3:0]  m_frame_type,
    output logic [5:0]  m_frame_bytes,
    output logic [11:0] m_bitrate_10bps,
    output logic [31:0] m_good_frames,
    output logic [26:0] m_length_seconds,
    output logic        m_irregular,
    output logic        m_done_res
);
    import amr_sfs_pkg::*;

    `include "amr_storage_frame_scanner_top_defines.svh"

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_HUNT,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    // Scan state
    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [3:0]  flags_reg, flags_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [3:0]  chans_reg, chans_next;
    logic [7:0]  locked_reg, locked_next;
    logic        lock_reg, lock_next;
    logic [5:0]  left_reg, left_next;
    logic        irr_reg, irr_next;

    // Result register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  ev_reg;
    logic [1:0]  fmt_out_reg;
    logic [3:0]  chans_out_reg;
    logic [3:0]  ft_out_reg;
    logic [5:0]  bytes_out_reg;
    logic [11:0] rate_out_reg;
    logic [31:0] frames_out_reg;
    logic [26:0] secs_out_reg;
    logic        irr_out_reg;
    logic        done_out_reg;

    logic                   advance;
    logic                   out_free;
    logic [2:0]             ev;
    logic [3:0]             ft_out;
    logic                   cnt_inc;
    logic [7:0]             start_hdr;
    logic [5:0]             start_size;
    logic [5:0]             start_left;
    logic [5:0]             left_dec;
    logic [5:0]             bytes_out;
    logic [11:0]            rate_out;
    logic [COUNT_WIDTH-1:0] frames_next;
    logic [COUNT_WIDTH-1:0] secs_next;

    amr_sfs_hdr_res_t  hdr_res;
    amr_sfs_hunt_res_t hunt_res;

    // Handshake: the result register frees when empty or taken
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    amr_sfs_magic u_magic (
        .data_byte (in_data_reg),
        .pos       (pos_reg),
        .flags     (flags_reg),
        .res       (hdr_res)
    );

    amr_sfs_hunt u_hunt (
        .data_byte (in_data_reg),
        .fmt       (fmt_reg),
        .locked    (locked_reg),
        .have_lock (lock_reg),
        .res       (hunt_res)
    );

    amr_sfs_count u_count (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .clear       (in_last_reg),
        .inc         (cnt_inc),
        .frames_next (frames_next),
        .secs_next   (secs_next)
    );

    // Payload length of a newly started frame
    assign start_hdr  = hunt_res.relock ? in_data_reg : locked_reg;
    assign start_size = mode_size(fmt_reg, start_hdr[6:3]);
    assign start_left = (start_size != '0) ? start_size - 6'd1 : '0;
    assign left_dec   = (left_reg != '0) ? left_reg - 6'd1 : '0;

    // Step the scan for the word in the input register
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        fmt_next   = fmt_reg;
        chans_next = chans_reg;
        locked_next = locked_reg;
        lock_next  = lock_reg;
        left_next  = left_reg;
        irr_next   = irr_reg;
        ev         = EV_HDR;
        ft_out     = '0;
        cnt_inc    = 1'b0;
        case (phase_reg)
            PH_HEADER: begin
                flags_next = hdr_res.flags;
                if (hdr_res.err) begin
                    ev         = EV_FMT_ERR;
                    phase_next = PH_ERROR;
                end else begin
                    ev       = EV_HDR;
                    pos_next = hdr_res.pos;
                    if (hdr_res.done) begin
                        fmt_next   = hdr_res.fmt;
                        chans_next = hdr_res.chans;
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_HUNT: begin
                ft_out   = in_data_reg[6:3];
                ev       = hunt_res.ev;
                irr_next = irr_reg || hunt_res.set_irr;
                cnt_inc  = hunt_res.count;
                if (hunt_res.relock) begin
                    locked_next = in_data_reg;
                    lock_next   = 1'b1;
                end
                if (hunt_res.count) begin
                    left_next  = start_left;
                    phase_next = (start_left != '0) ? PH_PAYLOAD : PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                ft_out     = locked_reg[6:3];
                ev         = EV_PAYLOAD;
                left_next  = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                ev = EV_FMT_ERR;
            end
        endcase
    end

    // Mode figures after the update
    assign bytes_out = lock_next ? mode_size(fmt_next, locked_next[6:3]) : '0;
    assign rate_out  = lock_next ? mode_rate(fmt_next, locked_next[6:3]) : '0;

    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Hold input, scan state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            flags_reg    <= '1;
            fmt_reg      <= FMT_UNKNOWN;
            chans_reg    <= 4'd1;
            locked_reg   <= '0;
            lock_reg     <= 1'b0;
            left_reg     <= '0;
            irr_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                if (in_last_reg) begin
                    phase_reg  <= PH_HEADER;
                    pos_reg    <= '0;
                    flags_reg  <= '1;
                    fmt_reg    <= FMT_UNKNOWN;
                    chans_reg  <= 4'd1;
                    locked_reg <= '0;
                    lock_reg   <= 1'b0;
                    left_reg   <= '0;
                    irr_reg    <= 1'b0;
                end else begin
                    phase_reg  <= phase_next;
                    pos_reg    <= pos_next;
                    flags_reg  <= flags_next;
                    fmt_reg    <= fmt_next;
                    chans_reg  <= chans_next;
                    locked_reg <= locked_next;
                    lock_reg   <= lock_next;
                    left_reg   <= left_next;
                    irr_reg    <= irr_next;
                end
            end
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
        if (advance) begin
            ev_reg         <= ev;
            fmt_out_reg    <= fmt_next;
            chans_out_reg  <= chans_next;
            ft_out_reg     <= ft_out;
            bytes_out_reg  <= bytes_out;
            rate_out_reg   <= rate_out;
            frames_out_reg <= 32'(frames_next);
            secs_out_reg   <= 27'(secs_next);
            irr_out_reg    <= irr_next;
            done_out_reg   <= in_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_res      = ev_reg;
    assign m_format         = fmt_out_reg;
    assign m_channels       = chans_out_reg;
    assign m_frame_type     = ft_out_reg;
    assign m_frame_bytes    = bytes_out_reg;
    assign m_bitrate_10bps  = rate_out_reg;
    assign m_good_frames    = frames_out_reg;
    assign m_length_seconds = secs_out_reg;
    assign m_irregular      = irr_out_reg;
    assign m_done_res       = done_out_reg;

    // A payload word only follows a locked mode
    `AMR_SFS_ASSERT_IMP(a_payload_locked, m_valid && m_event_res == EV_PAYLOAD, m_frame_bytes != '0, "payload word without a locked mode")
    // SID, noise and bad words always mark the stream irregular
    `AMR_SFS_ASSERT_IMP(a_irregular_set, m_valid && (m_event_res == EV_SID || m_event_res == EV_NOISE || m_event_res == EV_BAD), m_irregular, "irregular word without irregular flag")
    // A counted frame leaves a nonzero frame count
    `AMR_SFS_ASSERT_IMP(a_count_nonzero, m_valid && (m_event_res == EV_GOOD || m_event_res == EV_NEW_MODE), m_good_frames != '0, "good frame with zero count")
    // An accepted word lands in the input register
    `AMR_SFS_ASSERT_NXT(a_input_held, s_valid && s_ready, in_valid_reg, "accepted word lost from input register")

endmodule
